### rtl/core/pbrsa_pkg.sv
`default_nettype none
package pbrsa_pkg;

	localparam int MOD_BITS = 16;
	localparam int EXP_BITS = 16;

	// operand width: holds a residue of 2**MOD_BITS and the nine-bit byte operand
	localparam int NW = (MOD_BITS + 1 > 9) ? MOD_BITS + 1 : 9;
	localparam int NCNT_W = $clog2(NW + 1);
	localparam int ECNT_W = $clog2(EXP_BITS + 1);
	localparam int CFG_W = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam logic [7:0] TEXT_OFS = 8'd96;
	localparam logic [7:0] FOLD_A_LO = 8'd65;
	localparam logic [7:0] FOLD_A_HI = 8'd90;
	localparam logic [7:0] FOLD_B_LO = 8'd97;
	localparam logic [7:0] FOLD_B_HI = 8'd120;
	localparam logic [7:0] FOLD_C_LO = 8'd10;
	localparam logic [7:0] FOLD_C_HI = 8'd15;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RED  = 5'b00010,
		ST_EXP  = 5'b00100,
		ST_SQR  = 5'b01000,
		ST_MUL  = 5'b10000
	} state_t;

	typedef struct packed {
		logic          go;
		logic [NW-1:0] a;
		logic [NW-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic          done;
		logic [NW-1:0] res;
	} mm_rsp_t;

endpackage
`default_nettype wire

### rtl/core/pbrsa_modmul.sv
`default_nettype none
module pbrsa_modmul (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pbrsa_pkg::mm_req_t           req,
	input  wire logic [pbrsa_pkg::NW-1:0]     n,
	output pbrsa_pkg::mm_rsp_t                rsp
);

	logic [pbrsa_pkg::NW-1:0]     a_q;
	logic [pbrsa_pkg::NW-1:0]     b_q;
	logic [pbrsa_pkg::NW-1:0]     acc_q;
	logic [pbrsa_pkg::NCNT_W-1:0] cnt_q;
	logic                         run_q;
	logic                         done_q;

	logic [pbrsa_pkg::NW:0] dbl;
	logic [pbrsa_pkg::NW:0] red1;
	logic [pbrsa_pkg::NW:0] sum;
	logic [pbrsa_pkg::NW:0] red2;
	logic [pbrsa_pkg::NW:0] n_x;

	// one multiplier bit per cycle, most significant first
	always_comb begin
		n_x = {1'b0, n};
		dbl = {acc_q, 1'b0};
		red1 = (dbl >= n_x) ? dbl - n_x : dbl;
		sum = red1 + (a_q[pbrsa_pkg::NW-1] ? {1'b0, b_q} : '0);
		red2 = (sum >= n_x) ? sum - n_x : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= pbrsa_pkg::NCNT_W'(pbrsa_pkg::NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pbrsa_pkg::NCNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= '0;
		end else if (run_q) begin
			a_q <= {a_q[pbrsa_pkg::NW-2:0], 1'b0};
			acc_q <= red2[pbrsa_pkg::NW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = acc_q;

endmodule
`default_nettype wire

### rtl/core/per_byte_rsa_modexp.sv
// channel   | ports                         | beat taken when
// ----------+-------------------------------+----------------------------------
// request   | start, busy, cmd, in_byte     | start high while busy low
// result    | done, out_byte                | done high (one cycle, no stall)
// config    | cfg_we, cfg_idx, cfg_wdata    | cfg_we high (write only)
//
// The work per request is set by the bit-serial modular multiplier, one
// multiplier bit per cycle, on NW = MOD_BITS+1 bits; it runs one squaring per
// exponent bit below the top set bit and one multiply per set bit, and is
// shared by base reduction, squaring and multiplying.
// Reset clears control and the registers (modulus 1, exponent 0).
// The receiver cannot stall: done lasts one cycle as busy falls.
`default_nettype none
module per_byte_rsa_modexp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                cmd,
	input  wire logic [7:0]                          in_byte,
	output logic                                     done,
	output logic [7:0]                               out_byte,
	input  wire logic                                cfg_we,
	input  wire logic [pbrsa_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [pbrsa_pkg::CFG_W-1:0]         cfg_wdata
);

	pbrsa_pkg::state_t                 state_q;
	logic [pbrsa_pkg::MOD_BITS-1:0]    modulus_q;
	logic [pbrsa_pkg::EXP_BITS-1:0]    exponent_q;
	logic [pbrsa_pkg::EXP_BITS-1:0]    e_q;
	logic [pbrsa_pkg::ECNT_W-1:0]      ecnt_q;
	logic [pbrsa_pkg::NW-1:0]          base_q;
	logic [pbrsa_pkg::NW-1:0]          res_q;
	logic                              seen_q;
	logic                              neg_q;
	logic                              odd_q;
	logic                              done_q;
	logic [7:0]                        out_q;

	pbrsa_pkg::mm_req_t                mm_req;
	pbrsa_pkg::mm_rsp_t                mm_rsp;
	logic [pbrsa_pkg::NW-1:0]          n_eff;

	logic [9:0]                        p_enc;
	logic [9:0]                        mag_enc;
	logic [7:0]                        p_dec;
	logic                              fold;
	logic [8:0]                        mag;
	logic                              neg;
	logic                              ebit;
	logic [7:0]                        k8;

	assign ebit = e_q[pbrsa_pkg::EXP_BITS-1];
	// zero modulus: work modulo 2**MOD_BITS, whose low byte matches the wrapped power
	assign n_eff = (modulus_q == '0) ? (pbrsa_pkg::NW'(1) << pbrsa_pkg::MOD_BITS)
	                                 : pbrsa_pkg::NW'(modulus_q);

	always_comb begin
		p_enc = {{2{in_byte[7]}}, in_byte} - {2'b00, pbrsa_pkg::TEXT_OFS};
		mag_enc = p_enc[9] ? 10'(-p_enc) : p_enc;
		p_dec = in_byte - pbrsa_pkg::TEXT_OFS;
		fold = (p_dec >= pbrsa_pkg::FOLD_A_LO && p_dec <= pbrsa_pkg::FOLD_A_HI) ||
		       (p_dec >= pbrsa_pkg::FOLD_B_LO && p_dec <= pbrsa_pkg::FOLD_B_HI) ||
		       (p_dec >= pbrsa_pkg::FOLD_C_LO && p_dec <= pbrsa_pkg::FOLD_C_HI);
		if (cmd == pbrsa_pkg::CMD_DECRYPT) begin
			mag = {fold, p_dec};
			neg = 1'b0;
		end else begin
			mag = mag_enc[8:0];
			neg = p_enc[9];
		end
		k8 = (neg_q && odd_q) ? 8'(-res_q[7:0]) : res_q[7:0];
	end

	always_comb begin
		mm_req.go = 1'b0;
		mm_req.a = res_q;
		mm_req.b = res_q;
		unique case (state_q)
			pbrsa_pkg::ST_IDLE: begin
				mm_req.go = start;
				mm_req.a = pbrsa_pkg::NW'(mag);
				mm_req.b = pbrsa_pkg::NW'(1);
			end
			pbrsa_pkg::ST_EXP: begin
				if (ecnt_q != '0) begin
					if (seen_q) begin
						mm_req.go = 1'b1;
					end else if (ebit) begin
						mm_req.go = 1'b1;
						mm_req.b = base_q;
					end
				end
			end
			pbrsa_pkg::ST_SQR: begin
				mm_req.go = mm_rsp.done && ebit;
				mm_req.a = mm_rsp.res;
				mm_req.b = base_q;
			end
			pbrsa_pkg::ST_RED, pbrsa_pkg::ST_MUL: begin
				mm_req.go = 1'b0;
			end
			default: begin
				mm_req.go = 1'b0;
			end
		endcase
	end

	pbrsa_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.n      (n_eff),
		.rsp    (mm_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= pbrsa_pkg::MOD_BITS'(1);
			exponent_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pbrsa_pkg::REG_MODULUS:  modulus_q <= cfg_wdata[pbrsa_pkg::MOD_BITS-1:0];
				pbrsa_pkg::REG_EXPONENT: exponent_q <= cfg_wdata[pbrsa_pkg::EXP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbrsa_pkg::ST_IDLE;
			done_q <= 1'b0;
			seen_q <= 1'b0;
			ecnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				pbrsa_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= pbrsa_pkg::ST_RED;
						seen_q <= 1'b0;
						ecnt_q <= pbrsa_pkg::ECNT_W'(pbrsa_pkg::EXP_BITS);
					end
				end
				pbrsa_pkg::ST_RED: begin
					if (mm_rsp.done) begin
						state_q <= pbrsa_pkg::ST_EXP;
					end
				end
				pbrsa_pkg::ST_EXP: begin
					if (ecnt_q == '0) begin
						state_q <= pbrsa_pkg::ST_IDLE;
						done_q <= 1'b1;
					end else if (seen_q) begin
						state_q <= pbrsa_pkg::ST_SQR;
					end else if (ebit) begin
						seen_q <= 1'b1;
						state_q <= pbrsa_pkg::ST_MUL;
					end else begin
						ecnt_q <= ecnt_q - 1'b1;
					end
				end
				pbrsa_pkg::ST_SQR: begin
					if (mm_rsp.done) begin
						if (ebit) begin
							state_q <= pbrsa_pkg::ST_MUL;
						end else begin
							state_q <= pbrsa_pkg::ST_EXP;
							ecnt_q <= ecnt_q - 1'b1;
						end
					end
				end
				pbrsa_pkg::ST_MUL: begin
					if (mm_rsp.done) begin
						state_q <= pbrsa_pkg::ST_EXP;
						ecnt_q <= ecnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= pbrsa_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pbrsa_pkg::ST_IDLE: begin
				if (start) begin
					e_q <= exponent_q;
					odd_q <= exponent_q[0];
					neg_q <= neg;
					res_q <= pbrsa_pkg::NW'(1);
				end
			end
			pbrsa_pkg::ST_RED: begin
				if (mm_rsp.done) begin
					base_q <= mm_rsp.res;
				end
			end
			pbrsa_pkg::ST_EXP: begin
				if (ecnt_q == '0) begin
					out_q <= k8 + pbrsa_pkg::TEXT_OFS;
				end else if (!seen_q && !ebit) begin
					e_q <= {e_q[pbrsa_pkg::EXP_BITS-2:0], 1'b0};
				end
			end
			pbrsa_pkg::ST_SQR: begin
				if (mm_rsp.done) begin
					res_q <= mm_rsp.res;
					if (!ebit) begin
						e_q <= {e_q[pbrsa_pkg::EXP_BITS-2:0], 1'b0};
					end
				end
			end
			pbrsa_pkg::ST_MUL: begin
				if (mm_rsp.done) begin
					res_q <= mm_rsp.res;
					e_q <= {e_q[pbrsa_pkg::EXP_BITS-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != pbrsa_pkg::ST_IDLE);
	assign done = done_q;
	assign out_byte = out_q;

endmodule
`default_nettype wire

### rtl/core/pbrsa_chk.sv
`default_nettype none
module pbrsa_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request beat did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held over two cycles");

endmodule

bind per_byte_rsa_modexp pbrsa_chk u_pbrsa_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
`default_nettype wire
